@@ rtl/scalar_kalman_smoother_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SCALAR_KALMAN_SMOOTHER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_SMOOTHER_CORE_ASSERT_SVH

// same-cycle implication
`define SKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scalar_kalman_smoother_core check failed");

// next-cycle implication
`define SKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scalar_kalman_smoother_core check failed");

`endif

@@ rtl/sks_pkg.sv @@
`default_nettype none
package sks_pkg;

	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// covariance and noise registers, unsigned Q8.16
	localparam int COV_BITS = 24;

	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [COV_BITS-1:0] PNOISE_RST = 24'd0;
	localparam logic [COV_BITS-1:0] MNOISE_RST = 24'd655;
	localparam logic [COV_BITS-1:0] ICOV_RST   = 24'd65536;
	localparam logic [COV_BITS-1:0] COV_RST    = 24'd65536;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_PNOISE = 2'd0;
	localparam logic [1:0] REG_MNOISE = 2'd1;
	localparam logic [1:0] REG_ICOV   = 2'd2;
	localparam logic [1:0] REG_IEST   = 2'd3;

	typedef struct packed {
		logic start;
		logic den_zero;
	} sks_ctl_t;

endpackage
`default_nettype wire

@@ rtl/sks_if.sv @@
`default_nettype none
interface sks_in_if #(
	parameter int SAMPLE_BITS = sks_pkg::SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   restart;

	modport source(output valid, sample, restart, input ready);
	modport sink(input valid, sample, restart, output ready);
endinterface

interface sks_out_if #(
	parameter int SAMPLE_BITS    = sks_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = sks_pkg::GAIN_FRAC_BITS_DEF
) ();
	logic                      valid;
	logic                      ready;
	logic [SAMPLE_BITS-1:0]    estimate;
	logic [GAIN_FRAC_BITS:0]   gain;

	modport source(output valid, estimate, gain, input ready);
	modport sink(input valid, estimate, gain, output ready);
endinterface
`default_nettype wire

@@ rtl/sks_divmac.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first. Each quotient bit
// also drives two shift-add accumulators: gain*diff and gain*pred.
module sks_divmac #(
	parameter int SAMPLE_BITS    = sks_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = sks_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sks_pkg::sks_ctl_t                     ctl,
	input  wire logic [sks_pkg::COV_BITS-1:0]          pred,
	input  wire logic [sks_pkg::COV_BITS:0]            den,
	input  wire logic signed [SAMPLE_BITS:0]           diff,
	output logic                                       done,
	output logic [GAIN_FRAC_BITS:0]                    gain,
	output logic signed [SAMPLE_BITS+GAIN_FRAC_BITS:0] macc,
	output logic [sks_pkg::COV_BITS+GAIN_FRAC_BITS-1:0] mprod
);
	import sks_pkg::*;

	localparam int G  = GAIN_FRAC_BITS;
	localparam int MW = SAMPLE_BITS + G + 1;
	localparam int MP = COV_BITS + G;
	localparam int CW = $clog2(G + 2);

	logic [COV_BITS:0]           rem_q;
	logic [COV_BITS:0]           den_q;
	logic [COV_BITS-1:0]         pred_q;
	logic signed [SAMPLE_BITS:0] diff_q;
	logic                        zero_q;
	logic                        first_q;
	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [G:0]                  quo_q;
	logic signed [MW-1:0]        macc_q;
	logic [MP-1:0]               mprod_q;

	logic [COV_BITS+1:0] trial;
	logic [COV_BITS+1:0] trial_sub;
	logic                ge;
	logic [MW-1:0]       diff_ext;

	// first step compares pred against den unshifted (integer quotient bit)
	assign trial     = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = !zero_q && (trial >= {1'b0, den_q});
	assign diff_ext  = {{(MW-SAMPLE_BITS-1){diff_q[SAMPLE_BITS]}}, diff_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			den_q   <= '0;
			pred_q  <= '0;
			diff_q  <= '0;
			zero_q  <= 1'b0;
			first_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			quo_q   <= '0;
			macc_q  <= '0;
			mprod_q <= '0;
		end else if (ctl.start) begin
			rem_q   <= {1'b0, pred};
			den_q   <= den;
			pred_q  <= pred;
			diff_q  <= diff;
			zero_q  <= ctl.den_zero;
			first_q <= 1'b1;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			cnt_q   <= CW'(G);
			quo_q   <= '0;
			macc_q  <= '0;
			mprod_q <= '0;
		end else if (busy_q) begin
			rem_q   <= ge ? trial_sub[COV_BITS:0] : trial[COV_BITS:0];
			quo_q   <= {quo_q[G-1:0], ge};
			macc_q  <= (macc_q <<< 1) + (ge ? $signed(diff_ext) : $signed(MW'(0)));
			mprod_q <= {mprod_q[MP-2:0], 1'b0} + (ge ? MP'(pred_q) : MP'(0));
			first_q <= 1'b0;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done  = done_q;
	assign gain  = quo_q;
	assign macc  = macc_q;
	assign mprod = mprod_q;

endmodule
`default_nettype wire

@@ rtl/scalar_kalman_smoother_core.sv @@
`default_nettype none
// Scalar Kalman filter, constant-state model, fixed point.
// meas (sink): one measurement transaction = sample (unsigned Q12.4) + restart.
//   restart reloads estimate and covariance from the initial registers first.
// filt (source): one result transaction per measurement = estimate + gain (Q1.16).
// APB port: process_noise @0x0, measurement_noise @0x4, initial_covariance @0x8,
//   initial_estimate @0xC; pready is tied high, reads return register values.
//   Write registers only while the filter is idle.
// Timing: one measurement at a time. After acceptance the step runs through
//   ST_PRED, ST_KICK, ST_RUN and ST_FIN; ST_FIN loads the result and goes back
//   to ST_IDLE to accept the next measurement. ST_RUN waits for the restoring
//   divider in sks_divmac, one gain bit per cycle over GAIN_FRAC_BITS+1 steps.
// A finished result sits in the output register; meas.ready returns as soon as
//   the result is loaded, even if filt is stalled. A stall only holds the next
//   result in its final stage until the previous one is taken.
// Reset (arst_n low): registers to defaults, estimate 0, covariance 1.0,
//   output empty.
module scalar_kalman_smoother_core #(
	parameter int SAMPLE_BITS    = sks_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = sks_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	sks_in_if.sink                                    meas,
	sks_out_if.source                                 filt,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [sks_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  wire logic [sks_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [sks_pkg::APB_DATA_BITS-1:0]         prdata,
	output logic                                      pready
);
	import sks_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int G  = GAIN_FRAC_BITS;
	localparam int MW = SB + G + 1;          // gain*diff, signed
	localparam int MP = COV_BITS + G;        // gain*pred
	localparam int AW = SB + G + 2;          // estimate accumulator, signed

	localparam logic [AW-1:0] HALF_X = AW'(64'd1 << (G - 1));
	localparam logic [MP-1:0] HALF_C = MP'(64'd1 << (G - 1));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_KICK,
		ST_RUN,
		ST_FIN
	} state_t;

	// configuration registers
	logic [COV_BITS-1:0] pnoise_q;
	logic [COV_BITS-1:0] mnoise_q;
	logic [COV_BITS-1:0] icov_q;
	logic [SB-1:0]       iest_q;
	logic [1:0]          reg_idx;

	// filter state and per-step working registers
	state_t              state_q;
	logic [SB-1:0]       x_q;
	logic [COV_BITS-1:0] cov_q;
	logic [SB-1:0]       z_q;
	logic [COV_BITS-1:0] pred_q;
	logic [COV_BITS:0]   den_q;
	logic signed [SB:0]  diff_q;
	logic                out_valid_q;
	logic [SB-1:0]       est_q;
	logic [G:0]          gain_q;

	// datapath
	logic [COV_BITS:0]    cov_sum;
	logic [COV_BITS-1:0]  pred_sat;
	sks_ctl_t             unit_ctl;
	logic                 unit_done;
	logic [G:0]           unit_gain;
	logic signed [MW-1:0] unit_macc;
	logic [MP-1:0]        unit_mprod;
	logic signed [AW-1:0] acc_x;
	logic [SB+1:0]        x_new_raw;
	logic [SB-1:0]        x_new;
	logic [MP-1:0]        acc_c;
	logic                 accept;
	logic                 out_free;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q <= PNOISE_RST;
			mnoise_q <= MNOISE_RST;
			icov_q   <= ICOV_RST;
			iest_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PNOISE: pnoise_q <= pwdata[COV_BITS-1:0];
				REG_MNOISE: mnoise_q <= pwdata[COV_BITS-1:0];
				REG_ICOV:   icov_q   <= pwdata[COV_BITS-1:0];
				REG_IEST:   iest_q   <= pwdata[SB-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PNOISE: prdata = APB_DATA_BITS'(pnoise_q);
			REG_MNOISE: prdata = APB_DATA_BITS'(mnoise_q);
			REG_ICOV:   prdata = APB_DATA_BITS'(icov_q);
			REG_IEST:   prdata = APB_DATA_BITS'(iest_q);
			default:    prdata = '0;
		endcase
	end

	// prediction: saturating p + q
	assign cov_sum  = {1'b0, cov_q} + {1'b0, pnoise_q};
	assign pred_sat = cov_sum[COV_BITS] ? '1 : cov_sum[COV_BITS-1:0];

	assign unit_ctl.start    = (state_q == ST_KICK);
	assign unit_ctl.den_zero = (den_q == '0);

	sks_divmac #(
		.SAMPLE_BITS    (SB),
		.GAIN_FRAC_BITS (G)
	) u_divmac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.pred   (pred_q),
		.den    (den_q),
		.diff   (diff_q),
		.done   (unit_done),
		.gain   (unit_gain),
		.macc   (unit_macc),
		.mprod  (unit_mprod)
	);

	// x' = (x*2^G + gain*(z-x) + half) >> G, clamped
	assign acc_x = $signed({2'b00, x_q, {G{1'b0}}})
		+ $signed({unit_macc[MW-1], unit_macc}) + $signed(HALF_X);
	assign x_new_raw = acc_x[AW-1:G];
	always_comb begin
		if (x_new_raw[SB+1]) begin
			x_new = '0;
		end else if (x_new_raw[SB]) begin
			x_new = '1;
		end else begin
			x_new = x_new_raw[SB-1:0];
		end
	end

	// p' = (pred*2^G - gain*pred + half) >> G; never exceeds pred
	assign acc_c = {pred_q, {G{1'b0}}} - unit_mprod + HALF_C;

	assign accept   = meas.valid && meas.ready;
	assign out_free = !out_valid_q || filt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			cov_q       <= COV_RST;
			z_q         <= '0;
			pred_q      <= '0;
			den_q       <= '0;
			diff_q      <= '0;
			out_valid_q <= 1'b0;
			est_q       <= '0;
			gain_q      <= '0;
		end else begin
			// output register: load a finished step, else empty on a taken transaction
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (filt.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						z_q <= meas.sample;
						if (meas.restart) begin
							x_q   <= iest_q;
							cov_q <= icov_q;
						end
						state_q <= ST_PRED;
					end
				end
				ST_PRED: begin
					pred_q  <= pred_sat;
					den_q   <= {1'b0, pred_sat} + {1'b0, mnoise_q};
					diff_q  <= $signed({1'b0, z_q}) - $signed({1'b0, x_q});
					state_q <= ST_KICK;
				end
				ST_KICK: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (unit_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						x_q     <= x_new;
						cov_q   <= acc_c[MP-1:G];
						est_q   <= x_new;
						gain_q  <= unit_gain;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign meas.ready    = (state_q == ST_IDLE);
	assign filt.valid    = out_valid_q;
	assign filt.estimate = est_q;
	assign filt.gain     = gain_q;

endmodule
`default_nettype wire

@@ rtl/sks_checker.sv @@
`default_nettype none
`include "scalar_kalman_smoother_core_assert.svh"
module sks_checker #(
	parameter int SAMPLE_BITS    = sks_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = sks_pkg::GAIN_FRAC_BITS_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [SAMPLE_BITS-1:0]    estimate,
	input wire logic [GAIN_FRAC_BITS:0]   gain
);
	localparam logic [GAIN_FRAC_BITS:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

	// gain is a fraction in [0, 1]
	`SKS_ASSERT_IMP(a_gain_le_one, clk, arst_n, out_valid, gain <= GAIN_ONE)
	// one measurement in flight: busy right after acceptance
	`SKS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// result never appears the cycle after acceptance
	`SKS_ASSERT_NXT(a_no_instant_result, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)
	// stalled result holds
	`SKS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(estimate) && $stable(gain))

endmodule

bind scalar_kalman_smoother_core sks_checker #(
	.SAMPLE_BITS    (SAMPLE_BITS),
	.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_sks_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (meas.valid),
	.in_ready  (meas.ready),
	.out_valid (filt.valid),
	.out_ready (filt.ready),
	.estimate  (filt.estimate),
	.gain      (filt.gain)
);
`default_nettype wire
